// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl of the list engine
// no dependencies; each macro takes a label, clock, active-low reset, property and message
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== sv/cdll_pkg.sv =====
// package of the circular doubly linked list engine: types, codes and constants
// used by cdll_cell, cdll_tap and circular_doubly_linked_list_engine; no dependencies
package cdll_pkg;

  // default node pool size
  localparam int unsigned Capacity = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_PUSH_BACK    = 3'd1,
    OP_INSERT_AFTER = 3'd2,
    OP_POP_FRONT    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_REMOVE_KEY   = 3'd5,
    OP_READ_OUT     = 3'd6,
    OP_NOP          = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // input item
  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] key;
  } req_t;

  // result item
  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] data;
    logic                    data_valid;
    logic                    last;
    logic [CountW-1:0]       element_count;
  } rsp_t;

  // one list element held in a ring cell
  typedef struct packed {
    logic             occ;
    logic [DataW-1:0] val;
  } entry_t;

  // control from the sequencer to the tap
  typedef struct packed {
    logic             start;
    logic             step;
    opcode_e          opcode;
    logic [DataW-1:0] value;
    logic [DataW-1:0] key;
    logic             is_first;
    logic             is_tail;
    logic             full;
  } tap_ctrl_t;

  // status from the tap back to the sequencer
  typedef struct packed {
    logic             found;
    logic [DataW-1:0] rem_val;
  } tap_stat_t;

endpackage

// ===== sv/cdll_cell.sv =====
// one cell of the element ring: holds a single list entry
// depends on cdll_pkg for the entry type
module cdll_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  cdll_pkg::entry_t d_i,
  output cdll_pkg::entry_t q_o
);

  logic                      occ_q;
  logic [cdll_pkg::DataW-1:0] val_q;

  // occupancy flag, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (shift_i) begin
      occ_q <= d_i.occ;
    end
  end

  // element value, taken from the neighbour on every ring step
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= d_i.val;
    end
  end

  assign q_o = '{occ: occ_q, val: val_q};

endmodule

// ===== sv/cdll_tap.sv =====
// stream edit point of the element ring: delays, inserts or drops one entry per pass
// depends on cdll_pkg for the entry, control and status types
module cdll_tap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdll_pkg::tap_ctrl_t ctrl_i,
  input  cdll_pkg::entry_t    x_i,
  output cdll_pkg::entry_t    y_o,
  output cdll_pkg::tap_stat_t stat_o
);

  // latency of the tap in ring steps
  typedef enum logic [2:0] {
    LAT0 = 3'b001,
    LAT1 = 3'b010,
    LAT2 = 3'b100
  } lat_e;

  cdll_pkg::entry_t             a_q, a_d, b_q, b_d, new_e;
  lat_e                         mode_q, mode_d;
  logic                         done_q, done_d;
  logic                         found_q, found_d;
  logic [cdll_pkg::DataW-1:0]   rem_q, rem_d;
  logic                         hit;
  logic                         take;

  assign new_e = '{occ: 1'b1, val: ctrl_i.value};
  assign hit   = x_i.occ && (x_i.val == ctrl_i.key);

  // which entry a removal drops
  always_comb begin
    case (ctrl_i.opcode)
      cdll_pkg::OP_POP_FRONT:  take = ctrl_i.is_first;
      cdll_pkg::OP_POP_BACK:   take = ctrl_i.is_tail;
      cdll_pkg::OP_REMOVE_KEY: take = hit;
      default:                 take = 1'b0;
    endcase
  end

  // delay line plus the single edit of this pass
  always_comb begin
    y_o     = b_q;
    a_d     = a_q;
    b_d     = b_q;
    mode_d  = mode_q;
    done_d  = done_q;
    found_d = found_q;
    rem_d   = rem_q;
    if (ctrl_i.start) begin
      b_d     = '{occ: 1'b0, val: '0};
      mode_d  = LAT1;
      done_d  = 1'b0;
      found_d = 1'b0;
    end else if (ctrl_i.step) begin
      unique case (mode_q)
        LAT0: y_o = x_i;
        LAT1: begin
          y_o = b_q;
          b_d = x_i;
        end
        LAT2: begin
          y_o = a_q;
          a_d = b_q;
          b_d = x_i;
        end
        default: y_o = b_q;
      endcase
      if (!done_q) begin
        case (ctrl_i.opcode)
          cdll_pkg::OP_PUSH_FRONT: begin
            if (ctrl_i.is_first) begin
              a_d    = new_e;
              b_d    = x_i;
              mode_d = LAT2;
              done_d = 1'b1;
            end
          end
          cdll_pkg::OP_PUSH_BACK: begin
            // first free cell after the tail takes the new entry
            if (!x_i.occ) begin
              b_d    = new_e;
              done_d = 1'b1;
            end
          end
          cdll_pkg::OP_INSERT_AFTER: begin
            if (hit) begin
              found_d = 1'b1;
              done_d  = 1'b1;
              if (!ctrl_i.full) begin
                a_d    = x_i;
                b_d    = new_e;
                mode_d = LAT2;
              end
            end
          end
          default: begin
            if (take) begin
              b_d     = b_q;
              mode_d  = LAT0;
              found_d = 1'b1;
              done_d  = 1'b1;
              rem_d   = x_i.val;
            end
          end
        endcase
      end
    end
  end

  // control flags of the pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= LAT1;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  // delay registers and removed value
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

  assign stat_o = '{found: found_q, rem_val: rem_q};

endmodule

// ===== sv/circular_doubly_linked_list_engine.sv =====
// Channel | Direction | Handshake                  | Payload
// req     | in        | in_valid_i / in_ready_o    | req_i  (cdll_pkg::req_t)
// rsp     | out       | out_valid_o / out_ready_i  | rsp_o  (cdll_pkg::rsp_t)
//
// Flow: a push on a full pool, an opcode without effect and any operation on an
// empty list answer at the transfer. Every other operation makes one
// pass of the element ring, CAPACITY+1 steps: a read out emits one element per step
// until all elements are out; inserts and removals load the result in the S_FIN state
// after the pass. The ring stalls while a read out result is held.
// Reset clears all cell occupancy flags at once; new items are taken between passes.
//
// top level of the list engine; depends on cdll_pkg, cdll_cell, cdll_tap, assert_macros.svh
`include "assert_macros.svh"

module circular_doubly_linked_list_engine #(
  parameter int unsigned CAPACITY = cdll_pkg::Capacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cdll_pkg::req_t    req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cdll_pkg::rsp_t    rsp_o
);

  localparam int unsigned LW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [LW-1:0]           len_q, len_d;
  logic [LW-1:0]           k_q, k_d;
  cdll_pkg::opcode_e       op_q, in_op;
  logic [cdll_pkg::DataW-1:0] value_q, key_q;
  logic                    out_valid_q;
  cdll_pkg::rsp_t          out_q, rsp_d;
  logic                    out_free, accept, imm, step, emit_read, fin_load, load;
  logic                    full;
  logic [1:0]              imm_status;
  cdll_pkg::tap_ctrl_t     tap_ctrl;
  cdll_pkg::tap_stat_t     tap_stat;
  cdll_pkg::entry_t        tap_out;
  cdll_pkg::entry_t        cell_q [CAPACITY];
  logic [CAPACITY-1:0]     occ_vec;
  logic                    idle;
  logic [LW-1:0]           occ_cnt;
  logic                    occ_packed;

  assign in_op    = cdll_pkg::opcode_e'(req_i.opcode);
  assign full     = (len_q == LW'(CAPACITY));
  assign out_free = !out_valid_q || out_ready_i;

  // decode of an incoming item: answer at once or start a ring pass
  always_comb begin
    imm        = 1'b1;
    imm_status = cdll_pkg::ST_DONE;
    unique case (in_op) inside
      cdll_pkg::OP_PUSH_FRONT, cdll_pkg::OP_PUSH_BACK: begin
        if (full) begin
          imm_status = cdll_pkg::ST_FULL;
        end else begin
          imm = 1'b0;
        end
      end
      cdll_pkg::OP_INSERT_AFTER, cdll_pkg::OP_POP_FRONT, cdll_pkg::OP_POP_BACK,
      cdll_pkg::OP_REMOVE_KEY, cdll_pkg::OP_READ_OUT: begin
        if (len_q == '0) begin
          imm_status = cdll_pkg::ST_EMPTY;
        end else begin
          imm = 1'b0;
        end
      end
      default: imm_status = cdll_pkg::ST_DONE;
    endcase
  end

  // handshakes and ring step enable
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = (state_q == S_RUN) && ((op_q != cdll_pkg::OP_READ_OUT) || out_free);
  assign emit_read  = step && (op_q == cdll_pkg::OP_READ_OUT) && (k_q < len_q);
  assign fin_load   = (state_q == S_FIN) && out_free;
  assign load       = (accept && imm) || emit_read || fin_load;

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    len_d   = len_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !imm) begin
          state_d = S_RUN;
          k_d     = '0;
        end
      end
      S_RUN: begin
        if (step) begin
          k_d = k_q + LW'(1);
          if (k_q == LW'(CAPACITY)) begin
            state_d = (op_q == cdll_pkg::OP_READ_OUT) ? S_IDLE : S_FIN;
          end
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
          unique case (op_q) inside
            cdll_pkg::OP_PUSH_FRONT, cdll_pkg::OP_PUSH_BACK: len_d = len_q + LW'(1);
            cdll_pkg::OP_INSERT_AFTER: begin
              if (tap_stat.found && !full) begin
                len_d = len_q + LW'(1);
              end
            end
            cdll_pkg::OP_POP_FRONT, cdll_pkg::OP_POP_BACK, cdll_pkg::OP_REMOVE_KEY: begin
              if (tap_stat.found) begin
                len_d = len_q - LW'(1);
              end
            end
            default: len_d = len_q;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result of the item in flight
  always_comb begin
    rsp_d = '{status: imm_status, data: '0, data_valid: 1'b0, last: 1'b1,
              element_count: cdll_pkg::CountW'(len_q)};
    if (state_q == S_RUN) begin
      rsp_d.status     = cdll_pkg::ST_DONE;
      rsp_d.data       = cell_q[0].val;
      rsp_d.data_valid = 1'b1;
      rsp_d.last       = (k_q == len_q - LW'(1));
    end else if (state_q == S_FIN) begin
      rsp_d.status        = cdll_pkg::ST_DONE;
      rsp_d.element_count = cdll_pkg::CountW'(len_d);
      case (op_q) inside
        cdll_pkg::OP_INSERT_AFTER: begin
          if (!tap_stat.found) begin
            rsp_d.status = cdll_pkg::ST_NOT_FOUND;
          end else if (full) begin
            rsp_d.status = cdll_pkg::ST_FULL;
          end
        end
        cdll_pkg::OP_POP_FRONT, cdll_pkg::OP_POP_BACK, cdll_pkg::OP_REMOVE_KEY: begin
          if (tap_stat.found) begin
            rsp_d.data       = tap_stat.rem_val;
            rsp_d.data_valid = 1'b1;
          end else begin
            rsp_d.status = cdll_pkg::ST_NOT_FOUND;
          end
        end
        default: rsp_d.status = cdll_pkg::ST_DONE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      k_q     <= k_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: request in flight and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      value_q <= req_i.value;
      key_q   <= req_i.key;
    end
    if (load) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  // tap at the wrap point of the ring
  assign tap_ctrl = '{start: accept && !imm, step: step, opcode: op_q, value: value_q,
                      key: key_q, is_first: (k_q == '0),
                      is_tail: (k_q == len_q - LW'(1)), full: full};

  cdll_tap u_tap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tap_ctrl),
    .x_i    (cell_q[0]),
    .y_o    (tap_out),
    .stat_o (tap_stat)
  );

  // ring of element cells, head at cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_end
      cdll_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (step),
        .d_i     (tap_out),
        .q_o     (cell_q[i])
      );
    end else begin : g_mid
      cdll_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (step),
        .d_i     (cell_q[i+1]),
        .q_o     (cell_q[i])
      );
    end
    assign occ_vec[i] = cell_q[i].occ;
  end

  // occupancy summary between passes
  assign idle       = (state_q == S_IDLE);
  assign occ_cnt    = LW'($countones(occ_vec));
  assign occ_packed = (((occ_vec + CAPACITY'(1)) & occ_vec) == '0);

  // checks
  `ASSERT_PROP(a_len_range, clk_i, rst_ni, len_q <= LW'(CAPACITY), "list length above capacity")
  `ASSERT_PROP(a_occ_count, clk_i, rst_ni, idle |-> (occ_cnt == len_q), "occupancy count wrong")
  `ASSERT_PROP(a_occ_packed, clk_i, rst_ni, idle |-> occ_packed, "entries not packed")
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, load && !out_free, "result register overwritten")

endmodule
